// ----- rtl/core/pfi_pkg.sv -----
// Shared types, codes and saturating helpers for the particle force integrator.
`default_nettype none
package pfi_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam logic [2:0] K_REPEL   = 3'd0;
	localparam logic [2:0] K_ATTRACT = 3'd1;
	localparam logic [2:0] K_STEER   = 3'd2;
	localparam logic [2:0] K_UPDATE  = 3'd3;
	localparam logic [2:0] K_LOAD    = 3'd4;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_DIFF,
		OP_SQ,
		OP_SQ_ACC,
		OP_SQRT,
		OP_DIV_F,
		OP_FCAP,
		OP_DIV_U,
		OP_UCAP,
		OP_M1,
		OP_M1CAP,
		OP_M2,
		OP_FWB,
		OP_ML,
		OP_STWB,
		OP_PLAIN,
		OP_UADD,
		OP_UMUL,
		OP_UWB,
		OP_LOAD,
		OP_OUT
	} pfi_op_t;

	typedef struct packed {
		pfi_op_t    op;
		logic [1:0] idx;
	} pfi_cmd_t;

	typedef struct packed {
		logic       unit_done;
		logic       len_zero;
		logic       in_reach;
		logic [2:0] kind;
		logic       arrival;
	} pfi_stat_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [30:0]        reach;
		logic signed [31:0] strength;
		logic               arrival_mode;
	} pfi_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               in_range;
	} pfi_res_t;

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v > 33'sh0_7FFF_FFFF) r = S32_MAX;
		else if (v < -33'sh0_8000_0000) r = S32_MIN;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat33({a[31], a} + {b[31], b});
	endfunction

	function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat33({a[31], a} - {b[31], b});
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] a);
		return a[31] ? (~a + 32'd1) : a;
	endfunction

	function automatic logic signed [31:0] sat_sm(input logic [64:0] m, input logic neg);
		logic signed [31:0] r;
		if (neg) r = (m > 65'h0_8000_0000) ? S32_MIN : (~m[31:0] + 32'd1);
		else r = (m > 65'h0_7FFF_FFFF) ? S32_MAX : m[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/pfi_if.sv -----
// Valid/ready channel interfaces for particle items and results.
`default_nettype none
interface pfi_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic [30:0]        reach;
	logic signed [31:0] strength;
	logic               arrival_mode;
	modport source(output valid, kind, point_x, point_y, point_z, reach, strength,
		arrival_mode, input ready);
	modport sink(input valid, kind, point_x, point_y, point_z, reach, strength,
		arrival_mode, output ready);
endinterface

interface pfi_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic               in_range;
	modport source(output valid, out_x, out_y, out_z, in_range, input ready);
	modport sink(input valid, out_x, out_y, out_z, in_range, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/particle_force_integrator.sv -----
// Top level: one particle with radial forces, steering and damped Euler update.
// Repel/attract in reach and steer with arrival run the square root and then the divider;
// out of reach or at zero length only the square root; plain steer, load, update and
// unknown kinds neither. The bit-serial square root and divider set the long paths.
// One item in flight; the next is taken in the cycle after its result enters the output register.
// Reset clears position, velocity and force sum and sets speed_factor to 1.0.
`default_nettype none
module particle_force_integrator #(
	parameter int FRAC_BITS = pfi_pkg::FRAC_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	pfi_in_if.sink     item,
	pfi_out_if.source  result,
	input  wire        cfg_we,
	input  wire [30:0] cfg_wdata
);
	import pfi_pkg::*;

	pfi_cmd_t  cmd;
	pfi_stat_t stat;
	pfi_item_t item_s;
	pfi_res_t  res_s;

	assign item_s.kind         = item.kind;
	assign item_s.point_x      = item.point_x;
	assign item_s.point_y      = item.point_y;
	assign item_s.point_z      = item.point_z;
	assign item_s.reach        = item.reach;
	assign item_s.strength     = item.strength;
	assign item_s.arrival_mode = item.arrival_mode;

	assign result.out_x    = res_s.out_x;
	assign result.out_y    = res_s.out_y;
	assign result.out_z    = res_s.out_z;
	assign result.in_range = res_s.in_range;

	pfi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pfi_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.item      (item_s),
		.res       (res_s),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

endmodule
`default_nettype wire

// ----- rtl/core/pfi_datapath.sv -----
// Datapath: particle state, shared multiplier, divider and square root unit.
`default_nettype none
module pfi_datapath #(
	parameter int FRAC_BITS = pfi_pkg::FRAC_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  pfi_pkg::pfi_cmd_t   cmd,
	output pfi_pkg::pfi_stat_t  stat,
	input  pfi_pkg::pfi_item_t  item,
	output pfi_pkg::pfi_res_t   res,
	input  wire                 cfg_we,
	input  wire [30:0]          cfg_wdata
);
	import pfi_pkg::*;

	localparam int NW  = 32 + FRAC_BITS;
	localparam int ITW = $clog2(NW + 1);
	localparam logic [32:0] ONE = 33'(1) << FRAC_BITS;

	logic [2:0]         kind_q;
	logic signed [31:0] pt_q [3];
	logic [30:0]        reach_q;
	logic signed [31:0] str_q;
	logic               arr_q;
	logic signed [31:0] d_q [3];
	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] acc_q [3];
	logic signed [31:0] res_q [3];
	logic               inr_q;
	logic [30:0]        spd_q;
	logic [63:0]        sum_q;
	logic [32:0]        fade_q;
	logic [32:0]        u_mag_q;
	logic               u_neg_q;
	logic [32:0]        t_mag_q;
	logic               t_neg_q;
	logic [64:0]        prod_q;
	logic [32:0]        mul_a;
	logic [31:0]        mul_b;
	logic [64:0]        prod_sh;
	logic               run_q;
	logic               sqrt_mode_q;
	logic [ITW-1:0]     cnt_q;
	logic [NW-1:0]      num_q;
	logic [NW-1:0]      quo_q;
	logic [31:0]        den_q;
	logic [31:0]        rem_q;
	logic [63:0]        sq_v_q;
	logic [33:0]        sq_rem_q;
	logic [31:0]        sq_root_q;
	logic [31:0]        len;
	logic [32:0]        dv_trial;
	logic [35:0]        sq_r2;
	logic [35:0]        sq_trial;
	logic signed [31:0] out_x_q, out_y_q, out_z_q;
	logic               out_inr_q;
	logic signed [31:0] f_w, u_w, v_w, p_w, t_w;
	logic [31:0]        dmag;

	assign len      = sq_root_q;
	assign prod_sh  = prod_q >> FRAC_BITS;
	assign dmag     = mag32(d_q[cmd.idx]);
	assign dv_trial = {rem_q, num_q[NW-1]};
	assign sq_r2    = {sq_rem_q, sq_v_q[63:62]};
	assign sq_trial = {2'b00, sq_root_q, 2'b01};

	assign stat.unit_done = !run_q;
	assign stat.len_zero  = (len == 32'd0);
	assign stat.in_reach  = (reach_q == 31'd0) || ({1'b0, len} <= {2'b00, reach_q});
	assign stat.kind      = kind_q;
	assign stat.arrival   = arr_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_SQ: begin
				mul_a = {1'b0, dmag};
				mul_b = dmag;
			end
			OP_M1: begin
				mul_a = u_mag_q;
				mul_b = mag32(str_q);
			end
			OP_M2: begin
				mul_a = t_mag_q;
				mul_b = fade_q[31:0];
			end
			OP_ML: begin
				mul_a = u_mag_q;
				mul_b = len;
			end
			OP_UMUL: begin
				mul_a = t_mag_q;
				mul_b = {1'b0, spd_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		f_w = sat_sm(prod_sh, t_neg_q);
		if (kind_q == K_ATTRACT) f_w = sat_sub(32'sd0, f_w);
		u_w = sat_sm(({1'b0, len} < ONE) ? prod_sh : {32'd0, u_mag_q}, u_neg_q);
		v_w = sat_sm(prod_sh, t_neg_q);
		p_w = sat_add(pos_q[cmd.idx], v_w);
		t_w = sat_add(vel_q[cmd.idx], acc_q[cmd.idx]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			spd_q <= 31'(ONE);
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				acc_q[i] <= '0;
			end
		end else begin
			if (cfg_we) spd_q <= cfg_wdata;
			if (run_q) begin
				cnt_q <= cnt_q - ITW'(1);
				if (cnt_q == ITW'(1)) run_q <= 1'b0;
				if (sqrt_mode_q) begin
					sq_v_q <= sq_v_q << 2;
					if (sq_r2 >= sq_trial) begin
						sq_rem_q  <= 34'(sq_r2 - sq_trial);
						sq_root_q <= {sq_root_q[30:0], 1'b1};
					end else begin
						sq_rem_q  <= sq_r2[33:0];
						sq_root_q <= {sq_root_q[30:0], 1'b0};
					end
				end else begin
					num_q <= num_q << 1;
					if (dv_trial >= {1'b0, den_q}) begin
						rem_q <= 32'(dv_trial - {1'b0, den_q});
						quo_q <= {quo_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= dv_trial[31:0];
						quo_q <= {quo_q[NW-2:0], 1'b0};
					end
				end
			end
			prod_q <= 65'(mul_a) * 65'(mul_b);
			unique case (cmd.op)
				OP_CAPTURE: begin
					kind_q   <= item.kind;
					pt_q[0]  <= item.point_x;
					pt_q[1]  <= item.point_y;
					pt_q[2]  <= item.point_z;
					reach_q  <= item.reach;
					str_q    <= item.strength;
					arr_q    <= item.arrival_mode;
					inr_q    <= 1'b0;
					for (int i = 0; i < 3; i++) res_q[i] <= '0;
				end
				OP_DIFF: begin
					for (int i = 0; i < 3; i++) begin
						if (kind_q == K_REPEL || kind_q == K_ATTRACT)
							d_q[i] <= sat_sub(pos_q[i], pt_q[i]);
						else
							d_q[i] <= sat_sub(pt_q[i], pos_q[i]);
					end
				end
				OP_SQ_ACC: sum_q <= ((cmd.idx == 2'd0) ? 64'd0 : sum_q) + prod_q[63:0];
				OP_SQRT: begin
					run_q       <= 1'b1;
					sqrt_mode_q <= 1'b1;
					cnt_q       <= ITW'(32);
					sq_v_q      <= sum_q;
					sq_rem_q    <= '0;
					sq_root_q   <= '0;
				end
				OP_DIV_F: begin
					run_q       <= 1'b1;
					sqrt_mode_q <= 1'b0;
					cnt_q       <= ITW'(NW);
					num_q       <= {1'b0, 31'(reach_q - len[30:0]), {FRAC_BITS{1'b0}}};
					den_q       <= {1'b0, reach_q};
					rem_q       <= '0;
					quo_q       <= '0;
				end
				OP_FCAP: fade_q <= (reach_q == 31'd0) ? ONE : quo_q[32:0];
				OP_DIV_U: begin
					run_q       <= 1'b1;
					sqrt_mode_q <= 1'b0;
					cnt_q       <= ITW'(NW);
					num_q       <= {dmag, {FRAC_BITS{1'b0}}};
					den_q       <= len;
					rem_q       <= '0;
					quo_q       <= '0;
				end
				OP_UCAP: begin
					u_mag_q <= (len == 32'd0) ? 33'd0 : quo_q[32:0];
					u_neg_q <= d_q[cmd.idx][31];
				end
				OP_M1CAP: begin
					t_mag_q <= prod_sh[32:0];
					t_neg_q <= u_neg_q ^ str_q[31];
				end
				OP_FWB: begin
					res_q[cmd.idx] <= f_w;
					acc_q[cmd.idx] <= sat_add(acc_q[cmd.idx], f_w);
					inr_q          <= 1'b1;
				end
				OP_STWB: res_q[cmd.idx] <= sat_sub(u_w, vel_q[cmd.idx]);
				OP_PLAIN: for (int i = 0; i < 3; i++) res_q[i] <= d_q[i];
				OP_UADD: begin
					t_mag_q <= {1'b0, mag32(t_w)};
					t_neg_q <= t_w[31];
				end
				OP_UWB: begin
					vel_q[cmd.idx] <= v_w;
					pos_q[cmd.idx] <= p_w;
					acc_q[cmd.idx] <= '0;
					res_q[cmd.idx] <= p_w;
				end
				OP_LOAD: begin
					for (int i = 0; i < 3; i++) begin
						pos_q[i] <= pt_q[i];
						vel_q[i] <= '0;
						acc_q[i] <= '0;
						res_q[i] <= pt_q[i];
					end
				end
				OP_OUT: begin
					out_x_q   <= res_q[0];
					out_y_q   <= res_q[1];
					out_z_q   <= res_q[2];
					out_inr_q <= inr_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign res.out_x    = out_x_q;
	assign res.out_y    = out_y_q;
	assign res.out_z    = out_z_q;
	assign res.in_range = out_inr_q;

endmodule
`default_nettype wire

// ----- rtl/core/pfi_ctrl.sv -----
// Controller: sequences the datapath for each item and holds the result handshake.
`default_nettype none
module pfi_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire                 out_ready,
	input  pfi_pkg::pfi_stat_t  stat,
	output pfi_pkg::pfi_cmd_t   cmd
);
	import pfi_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DIFF, S_SQ, S_SQACC, S_SQRT, S_SQRTW, S_FADE, S_FADEW, S_FCAP,
		S_DIVU, S_DIVUW, S_UCAP, S_M1, S_M1CAP, S_M2, S_FWB, S_ML, S_STWB,
		S_PLAIN, S_UADD, S_UMUL, S_UWB, S_LOAD, S_FIN
	} state_t;

	state_t     state_q;
	logic [1:0] idx_q;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.idx = idx_q;
		unique case (state_q)
			S_IDLE:  cmd.op = in_valid ? OP_CAPTURE : OP_NONE;
			S_DIFF:  cmd.op = OP_DIFF;
			S_SQ:    cmd.op = OP_SQ;
			S_SQACC: cmd.op = OP_SQ_ACC;
			S_SQRT:  cmd.op = OP_SQRT;
			S_FADE:  cmd.op = OP_DIV_F;
			S_FCAP:  cmd.op = OP_FCAP;
			S_DIVU:  cmd.op = OP_DIV_U;
			S_UCAP:  cmd.op = OP_UCAP;
			S_M1:    cmd.op = OP_M1;
			S_M1CAP: cmd.op = OP_M1CAP;
			S_M2:    cmd.op = OP_M2;
			S_FWB:   cmd.op = OP_FWB;
			S_ML:    cmd.op = OP_ML;
			S_STWB:  cmd.op = OP_STWB;
			S_PLAIN: cmd.op = OP_PLAIN;
			S_UADD:  cmd.op = OP_UADD;
			S_UMUL:  cmd.op = OP_UMUL;
			S_UWB:   cmd.op = OP_UWB;
			S_LOAD:  cmd.op = OP_LOAD;
			S_FIN:   cmd.op = (!out_valid_q || out_ready) ? OP_OUT : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DIFF;
				S_DIFF: begin
					idx_q <= 2'd0;
					priority if (stat.kind == K_REPEL || stat.kind == K_ATTRACT)
						state_q <= S_SQ;
					else if (stat.kind == K_STEER)
						state_q <= stat.arrival ? S_SQ : S_PLAIN;
					else if (stat.kind == K_UPDATE)
						state_q <= S_UADD;
					else if (stat.kind == K_LOAD)
						state_q <= S_LOAD;
					else
						state_q <= S_FIN;
				end
				S_SQ: state_q <= S_SQACC;
				S_SQACC: begin
					if (idx_q == 2'd2) begin
						idx_q   <= 2'd0;
						state_q <= S_SQRT;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= S_SQ;
					end
				end
				S_SQRT: state_q <= S_SQRTW;
				S_SQRTW: begin
					if (stat.unit_done) begin
						if (stat.kind == K_STEER)
							state_q <= stat.len_zero ? S_FIN : S_DIVU;
						else
							state_q <= stat.in_reach ? S_FADE : S_FIN;
					end
				end
				S_FADE:  state_q <= S_FADEW;
				S_FADEW: if (stat.unit_done) state_q <= S_FCAP;
				S_FCAP:  state_q <= S_DIVU;
				S_DIVU:  state_q <= S_DIVUW;
				S_DIVUW: if (stat.unit_done) state_q <= S_UCAP;
				S_UCAP:  state_q <= (stat.kind == K_STEER) ? S_ML : S_M1;
				S_M1:    state_q <= S_M1CAP;
				S_M1CAP: state_q <= S_M2;
				S_M2:    state_q <= S_FWB;
				S_ML:    state_q <= S_STWB;
				S_FWB, S_STWB: begin
					if (idx_q == 2'd2) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= S_DIVU;
					end
				end
				S_UADD: state_q <= S_UMUL;
				S_UMUL: state_q <= S_UWB;
				S_UWB: begin
					if (idx_q == 2'd2) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= S_UADD;
					end
				end
				S_PLAIN: state_q <= S_FIN;
				S_LOAD:  state_q <= S_FIN;
				S_FIN:   if (!out_valid_q || out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |-> (!out_valid_q || out_ready))
		else $error("result overwritten while pending");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_DIFF)
		else $error("accepted item not started");
	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_valid_q && !out_ready) |=> state_q == S_FIN)
		else $error("finished item left while result stalled");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd3)
		else $error("component index out of range");

endmodule
`default_nettype wire
